// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Action, status and order codes, controller states, and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int CW     = 32;                // component width
	localparam int DW     = 64;                // cross product width
	localparam int DIV_CW = $clog2(DW + 1);    // divider iteration counter
	localparam int KW     = $clog2(DW);        // gcd common power of two

	localparam logic [DW-1:0] HALF = DW'(1) << (CW - 1);

	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_MUL  = 3'd2,
		ACT_DIV  = 3'd3,
		ACT_REM  = 3'd4,
		ACT_NEG  = 3'd5,
		ACT_CMP  = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	localparam logic [1:0] MSEL_P0 = 2'd0;
	localparam logic [1:0] MSEL_P1 = 2'd1;
	localparam logic [1:0] MSEL_P2 = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_FORM,
		S_REMST,
		S_REMW,
		S_CHECK,
		S_GCD,
		S_DIVNS,
		S_DIVNW,
		S_DIVDS,
		S_DIVDW,
		S_FIN,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_FORM,
		OP_REMDIV,
		OP_REMFIX,
		OP_SETZERO,
		OP_SETONE,
		OP_GCDINIT,
		OP_GCDSTEP,
		OP_GCDEND,
		OP_DIVN,
		OP_TAKEN,
		OP_DIVD,
		OP_TAKED,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] msel;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    mn_zero;
		logic    md_zero;
		logic    gcd_done;
		logic    div_done;
	} dp_stat_t;

	function automatic logic [DW-1:0] mag64(input logic [DW-1:0] v);
		return v[DW-1] ? (DW'(0) - v) : v;
	endfunction

endpackage

// ----- rtl/rau_if.sv -----
// ----------------------------------------------------------------------------
// rau_if: operand and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface rau_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] a_num;
	logic [30:0]        a_den;
	logic signed [31:0] b_num;
	logic [30:0]        b_den;

	modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic [1:0]         status;
	logic [1:0]         order;

	modport source (output valid, res_num, res_den, status, order, input ready);
	modport sink (input valid, res_num, res_den, status, order, output ready);
endinterface

// ----- rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div: iterative unsigned divider
// Restoring shift-subtract division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [rau_pkg::DW-1:0] x,
	input  logic [rau_pkg::DW-1:0] y,
	output logic [rau_pkg::DW-1:0] q,
	output logic [rau_pkg::DW-1:0] r,
	output logic                   done
);

	logic [rau_pkg::DW-1:0]     q_q;
	logic [rau_pkg::DW-1:0]     r_q;
	logic [rau_pkg::DW-1:0]     y_q;
	logic [rau_pkg::DIV_CW-1:0] cnt_q;
	logic                       done_q;
	logic [rau_pkg::DW:0]       rs;
	logic [rau_pkg::DW:0]       diff;
	logic                       fits;

	always_comb begin
		rs   = {r_q, q_q[rau_pkg::DW-1]};
		diff = rs - {1'b0, y_q};
		fits = (rs >= {1'b0, y_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= rau_pkg::DIV_CW'(rau_pkg::DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == rau_pkg::DIV_CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= x;
			r_q <= '0;
			y_q <= y;
		end else if (cnt_q != '0) begin
			r_q <= fits ? diff[rau_pkg::DW-1:0] : rs[rau_pkg::DW-1:0];
			q_q <= {q_q[rau_pkg::DW-2:0], fits};
		end
	end

	assign q    = q_q;
	assign r    = r_q;
	assign done = done_q;

endmodule

// ----- rtl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, shared multiplier, binary gcd, divider and result regs.
// ----------------------------------------------------------------------------
module rau_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rau_pkg::dp_cmd_t   cmd,
	output rau_pkg::dp_stat_t  stat,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [1:0]         status,
	output logic [1:0]         order
);

	rau_pkg::action_t          act_q;
	logic signed [31:0]        an_q;
	logic [30:0]               ad_q;
	logic signed [31:0]        bn_q;
	logic [30:0]               bd_q;
	logic signed [63:0]        p0_q;
	logic signed [63:0]        p1_q;
	logic signed [63:0]        p2_q;
	logic [rau_pkg::DW-1:0]    mn_q;
	logic [rau_pkg::DW-1:0]    md_q;
	logic                      neg_q;
	logic [rau_pkg::DW-1:0]    u_q;
	logic [rau_pkg::DW-1:0]    v_q;
	logic [rau_pkg::KW-1:0]    k_q;
	logic [rau_pkg::DW-1:0]    g_q;
	logic signed [31:0]        num_q;
	logic [30:0]               den_q;
	logic [1:0]                st_q;
	logic [1:0]                ord_q;
	logic signed [31:0]        onum_q;
	logic [30:0]               oden_q;
	logic [1:0]                ost_q;
	logic [1:0]                oord_q;

	logic signed [32:0]        ma;
	logic signed [32:0]        mb;
	logic signed [65:0]        mprod;
	logic signed [63:0]        fn;
	logic signed [63:0]        fd;
	logic [1:0]                cmp_ord;
	logic [rau_pkg::DW-1:0]    nv;
	logic                      over;
	logic                      div_start;
	logic [rau_pkg::DW-1:0]    div_x;
	logic [rau_pkg::DW-1:0]    div_y;
	logic [rau_pkg::DW-1:0]    div_q;
	logic [rau_pkg::DW-1:0]    div_r;
	logic                      div_done;

	// shared multiplier, one cross product per cycle
	always_comb begin
		case (cmd.msel)
			rau_pkg::MSEL_P0: begin
				ma = {an_q[31], an_q};
				mb = (act_q == rau_pkg::ACT_MUL) ? {bn_q[31], bn_q} : {2'b00, bd_q};
			end
			rau_pkg::MSEL_P1: begin
				ma = {bn_q[31], bn_q};
				mb = {2'b00, ad_q};
			end
			default: begin
				ma = {2'b00, ad_q};
				mb = {2'b00, bd_q};
			end
		endcase
		mprod = ma * mb;
	end

	always_comb begin
		case (act_q) inside
			rau_pkg::ACT_ADD: begin
				fn = p0_q + p1_q;
				fd = p2_q;
			end
			rau_pkg::ACT_SUB: begin
				fn = p0_q - p1_q;
				fd = p2_q;
			end
			rau_pkg::ACT_MUL: begin
				fn = p0_q;
				fd = p2_q;
			end
			rau_pkg::ACT_NEG: begin
				fn = 64'sd0 - {{32{an_q[31]}}, an_q};
				fd = {33'd0, ad_q};
			end
			default: begin
				fn = p0_q;
				fd = p1_q;
			end
		endcase
		if (p0_q < p1_q)
			cmp_ord = rau_pkg::ORD_LT;
		else if (p0_q == p1_q)
			cmp_ord = rau_pkg::ORD_EQ;
		else
			cmp_ord = rau_pkg::ORD_GT;
	end

	// range check of the reduced fraction
	always_comb begin
		nv   = neg_q ? (rau_pkg::DW'(0) - mn_q) : mn_q;
		over = (md_q > rau_pkg::HALF - 1'b1) ||
		       (neg_q ? (mn_q > rau_pkg::HALF) : (mn_q > rau_pkg::HALF - 1'b1));
	end

	always_comb begin
		div_start = 1'b0;
		div_x     = mn_q;
		div_y     = md_q;
		unique case (cmd.op)
			rau_pkg::OP_REMDIV: div_start = 1'b1;
			rau_pkg::OP_DIVN: begin
				div_start = 1'b1;
				div_y     = g_q;
			end
			rau_pkg::OP_DIVD: begin
				div_start = 1'b1;
				div_x     = md_q;
				div_y     = g_q;
			end
			default: ;
		endcase
	end

	rau_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.x     (div_x),
		.y     (div_y),
		.q     (div_q),
		.r     (div_r),
		.done  (div_done)
	);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rau_pkg::OP_LOAD: begin
				act_q <= rau_pkg::action_t'(action);
				an_q  <= a_num;
				ad_q  <= a_den;
				bn_q  <= b_num;
				bd_q  <= b_den;
			end
			rau_pkg::OP_MUL: begin
				case (cmd.msel)
					rau_pkg::MSEL_P0: p0_q <= mprod[63:0];
					rau_pkg::MSEL_P1: p1_q <= mprod[63:0];
					default:          p2_q <= mprod[63:0];
				endcase
			end
			rau_pkg::OP_FORM: begin
				mn_q  <= rau_pkg::mag64(fn);
				md_q  <= rau_pkg::mag64(fd);
				neg_q <= fn[63] ^ fd[63];
				num_q <= '0;
				den_q <= '0;
				st_q  <= rau_pkg::ST_OK;
				ord_q <= (act_q == rau_pkg::ACT_CMP) ? cmp_ord : rau_pkg::ORD_LT;
			end
			rau_pkg::OP_REMFIX: begin
				mn_q  <= div_r;
				md_q  <= p2_q;
				neg_q <= p0_q[63];
			end
			rau_pkg::OP_SETZERO: begin
				num_q <= '0;
				den_q <= '0;
				st_q  <= rau_pkg::ST_ZERO;
				ord_q <= rau_pkg::ORD_LT;
			end
			rau_pkg::OP_SETONE: begin
				num_q <= '0;
				den_q <= 31'd1;
				st_q  <= rau_pkg::ST_OK;
				ord_q <= rau_pkg::ORD_LT;
			end
			rau_pkg::OP_GCDINIT: begin
				u_q <= mn_q;
				v_q <= md_q;
				k_q <= '0;
			end
			rau_pkg::OP_GCDSTEP: begin
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			rau_pkg::OP_GCDEND: g_q  <= (u_q | v_q) << k_q;
			rau_pkg::OP_TAKEN:  mn_q <= div_q;
			rau_pkg::OP_TAKED:  md_q <= div_q;
			rau_pkg::OP_FINISH: begin
				ord_q <= rau_pkg::ORD_LT;
				if (over) begin
					num_q <= '0;
					den_q <= '0;
					st_q  <= rau_pkg::ST_RANGE;
				end else begin
					num_q <= nv[31:0];
					den_q <= md_q[30:0];
					st_q  <= rau_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		if (cmd.emit) begin
			onum_q <= num_q;
			oden_q <= den_q;
			ost_q  <= st_q;
			oord_q <= ord_q;
		end
	end

	assign stat = '{
		act:      act_q,
		mn_zero:  (mn_q == '0),
		md_zero:  (md_q == '0),
		gcd_done: (u_q == '0) || (v_q == '0),
		div_done: div_done
	};

	assign res_num = onum_q;
	assign res_den = oden_q;
	assign status  = ost_q;
	assign order   = oord_q;

endmodule

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through products, reduction and result hand-off.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rau_pkg::dp_cmd_t  cmd,
	input  rau_pkg::dp_stat_t stat
);

	rau_pkg::state_t state_q;
	rau_pkg::state_t state_d;
	logic [1:0]      cnt_q;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == rau_pkg::S_MUL) ? cnt_q + 1'b1 : 2'd0;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '{op: rau_pkg::OP_NONE, msel: cnt_q, emit: 1'b0};
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = rau_pkg::OP_LOAD;
					state_d = rau_pkg::S_MUL;
				end
			end
			rau_pkg::S_MUL: begin
				cmd.op = rau_pkg::OP_MUL;
				if (cnt_q == rau_pkg::MSEL_P2)
					state_d = rau_pkg::S_FORM;
			end
			rau_pkg::S_FORM: begin
				cmd.op = rau_pkg::OP_FORM;
				case (stat.act) inside
					rau_pkg::ACT_CMP, rau_pkg::ACT_NONE: state_d = rau_pkg::S_EMIT;
					rau_pkg::ACT_REM:                    state_d = rau_pkg::S_REMST;
					default:                             state_d = rau_pkg::S_CHECK;
				endcase
			end
			rau_pkg::S_REMST: begin
				if (stat.md_zero) begin
					cmd.op  = rau_pkg::OP_SETZERO;
					state_d = rau_pkg::S_EMIT;
				end else begin
					cmd.op  = rau_pkg::OP_REMDIV;
					state_d = rau_pkg::S_REMW;
				end
			end
			rau_pkg::S_REMW: begin
				if (stat.div_done) begin
					cmd.op  = rau_pkg::OP_REMFIX;
					state_d = rau_pkg::S_CHECK;
				end
			end
			rau_pkg::S_CHECK: begin
				if (stat.md_zero) begin
					cmd.op  = rau_pkg::OP_SETZERO;
					state_d = rau_pkg::S_EMIT;
				end else if (stat.mn_zero) begin
					cmd.op  = rau_pkg::OP_SETONE;
					state_d = rau_pkg::S_EMIT;
				end else begin
					cmd.op  = rau_pkg::OP_GCDINIT;
					state_d = rau_pkg::S_GCD;
				end
			end
			rau_pkg::S_GCD: begin
				if (stat.gcd_done) begin
					cmd.op  = rau_pkg::OP_GCDEND;
					state_d = rau_pkg::S_DIVNS;
				end else begin
					cmd.op = rau_pkg::OP_GCDSTEP;
				end
			end
			rau_pkg::S_DIVNS: begin
				cmd.op  = rau_pkg::OP_DIVN;
				state_d = rau_pkg::S_DIVNW;
			end
			rau_pkg::S_DIVNW: begin
				if (stat.div_done) begin
					cmd.op  = rau_pkg::OP_TAKEN;
					state_d = rau_pkg::S_DIVDS;
				end
			end
			rau_pkg::S_DIVDS: begin
				cmd.op  = rau_pkg::OP_DIVD;
				state_d = rau_pkg::S_DIVDW;
			end
			rau_pkg::S_DIVDW: begin
				if (stat.div_done) begin
					cmd.op  = rau_pkg::OP_TAKED;
					state_d = rau_pkg::S_FIN;
				end
			end
			rau_pkg::S_FIN: begin
				cmd.op  = rau_pkg::OP_FINISH;
				state_d = rau_pkg::S_EMIT;
			end
			rau_pkg::S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = rau_pkg::S_IDLE;
				end
			end
			default: state_d = rau_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add, sub, mul, div, remainder, negate
// and compare with exact 64-bit reduction to lowest terms.
// ----------------------------------------------------------------------------
// The unit works on one transaction at a time. After an operand transaction
// it forms the cross products on one shared 33x33 multiplier, then forms
// the unreduced fraction; for compare or an unused action the result is
// then ready. Reducing operations run a binary gcd loop (one subtract or
// shift per cycle) followed by two exact divisions on the shared restoring
// divider; remainder adds one more division ahead of that. The result sits
// in an output register, so the next operand transaction is taken while the
// previous result still waits for its consumer. A zero denominator gives
// status 1, a reduced result outside 32-bit range gives status 2, and in
// both cases numerator and denominator read zero.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	rau_in_if.sink    in_ch,
	rau_out_if.source out_ch
);

	rau_pkg::dp_cmd_t  cmd;
	rau_pkg::dp_stat_t stat;

	// sequencer: handshakes and step control
	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// datapath: operand capture, arithmetic, result register
	rau_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.action (in_ch.action),
		.a_num  (in_ch.a_num),
		.a_den  (in_ch.a_den),
		.b_num  (in_ch.b_num),
		.b_den  (in_ch.b_den),
		.res_num(out_ch.res_num),
		.res_den(out_ch.res_den),
		.status (out_ch.status),
		.order  (out_ch.order)
	);

endmodule

// ----- rtl/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Bound to the top level; watches the channel handshakes and result fields.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic [1:0]  status,
	input logic [1:0]  order
);

	// hold a pending result until the consumer takes it
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item in flight: drop ready right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second operand taken while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rau_pkg::ST_OK |-> res_num == '0 && res_den == '0)
		else $error("failed result carries a fraction");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3 && order != 2'd3 &&
		(order == rau_pkg::ORD_LT || res_den == '0))
		else $error("bad status or order code");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.res_num  (out_ch.res_num),
	.res_den  (out_ch.res_den),
	.status   (out_ch.status),
	.order    (out_ch.order)
);

// ----- verif/tb_rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench for the fraction unit
// Drives operand transactions from a queue and predicts every result with an
// exact 64-bit fraction calculator. It checks each result field against the
// oldest prediction while both channels idle and stall through four phases.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;

	localparam int N_RANDOM    = 2000;
	localparam int DRAIN_WAIT  = 600;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} operands_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         status;
		logic [1:0]         order;
	} fraction_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rau_in_if  in_ch ();
	rau_out_if out_ch ();

	rational_arithmetic_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #6 clk = ~clk;

	operands_t pending_ops[$];
	fraction_t expected_fracs[$];
	int        total_ops;
	int        sent_ops = 0;
	int        taken_ops = 0;
	int        checked_fracs = 0;
	int        n_errors = 0;
	int        n_range = 0;
	int        n_zero = 0;
	longint    cycles = 0;
	logic      in_taken = 1'b0;

	// Reduce n/d to lowest terms with a positive denominator.
	function automatic fraction_t lowest_terms(input longint n, input longint d);
		fraction_t           r;
		longint unsigned     mn, md, x, y, t, half;
		bit                  neg;
		r = '0;
		if (d == 0) begin
			r.status = rau_pkg::ST_ZERO;
			return r;
		end
		if (n == 0) begin
			r.res_den = 31'd1;
			return r;
		end
		mn = (n < 0) ? (64'd0 - longint'(n)) : longint'(n);
		md = (d < 0) ? (64'd0 - longint'(d)) : longint'(d);
		neg = (n < 0) != (d < 0);
		x = mn;
		y = md;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		mn = mn / x;
		md = md / x;
		half = 64'd1 << 31;
		if (md > half - 1 || (neg ? (mn > half) : (mn > half - 1))) begin
			r.status = rau_pkg::ST_RANGE;
			return r;
		end
		r.res_num = neg ? 32'(64'd0 - mn) : 32'(mn);
		r.res_den = 31'(md);
		return r;
	endfunction

	function automatic fraction_t compute_fraction(input operands_t op);
		fraction_t r;
		longint    an, ad, bn, bd, lhs, rhs;
		an = longint'($signed(op.a_num));
		bn = longint'($signed(op.b_num));
		ad = longint'({33'd0, op.a_den});
		bd = longint'({33'd0, op.b_den});
		r = '0;
		case (rau_pkg::action_t'(op.action))
			rau_pkg::ACT_ADD: r = lowest_terms(an * bd + bn * ad, ad * bd);
			rau_pkg::ACT_SUB: r = lowest_terms(an * bd - bn * ad, ad * bd);
			rau_pkg::ACT_MUL: r = lowest_terms(an * bn, ad * bd);
			rau_pkg::ACT_DIV: r = lowest_terms(an * bd, ad * bn);
			rau_pkg::ACT_REM: begin
				// truncating remainder keeps the sign of the dividend
				lhs = an * bd;
				rhs = ad * bn;
				if (rhs == 0) r.status = rau_pkg::ST_ZERO;
				else r = lowest_terms(lhs % rhs, ad * bd);
			end
			rau_pkg::ACT_NEG: r = lowest_terms(-an, ad);
			rau_pkg::ACT_CMP: begin
				lhs = an * bd;
				rhs = bn * ad;
				r.order = (lhs < rhs) ? rau_pkg::ORD_LT :
				          ((lhs == rhs) ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_num();
		case ($urandom_range(9))
			0, 1, 2: return 32'($signed($urandom_range(40)) - 20);
			3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			4, 5:    return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_den();
		case ($urandom_range(99))
			0:             return 31'd0;
			1, 2, 3:       return 31'h7fff_ffff;
			4, 5, 6, 7:    return 31'd1;
			default: begin
				if ($urandom_range(1)) return 31'($urandom_range(60, 1));
				return 31'($urandom) | 31'd1 << $urandom_range(30);
			end
		endcase
	endfunction

	function automatic operands_t op(input rau_pkg::action_t act, input logic [31:0] an,
	                                 input logic [30:0] ad, input logic [31:0] bn,
	                                 input logic [30:0] bd);
		operands_t o;
		o.action = act;
		o.a_num = an;
		o.a_den = ad;
		o.b_num = bn;
		o.b_den = bd;
		return o;
	endfunction

	// Drive operands and consumer ready at the falling edge.
	always @(negedge clk) begin
		int idle_pct;
		int stall_pct;
		operands_t o;
		if (arst_n) begin
			case ((sent_ops * 4) / total_ops)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 63; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 7;  stall_pct = 7;  end
			endcase
			// hold the current transaction until it has been taken
			if (!in_ch.valid || in_taken) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
					o = pending_ops.pop_front();
					in_ch.action <= o.action;
					in_ch.a_num  <= o.a_num;
					in_ch.a_den  <= o.a_den;
					in_ch.b_num  <= o.b_num;
					in_ch.b_den  <= o.b_den;
					in_ch.valid  <= 1'b1;
					sent_ops++;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Predict on each operand transaction; check each result transaction.
	always @(posedge clk) begin
		operands_t o;
		fraction_t want;
		in_taken <= in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			o = {in_ch.action, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den};
			want = compute_fraction(o);
			if (want.status == rau_pkg::ST_RANGE) n_range++;
			if (want.status == rau_pkg::ST_ZERO) n_zero++;
			expected_fracs.push_back(want);
			taken_ops++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_fracs.size() == 0) begin
				$error("result with no prediction pending: %0d/%0d st %0d",
				       out_ch.res_num, out_ch.res_den, out_ch.status);
				n_errors++;
			end else begin
				want = expected_fracs.pop_front();
				checked_fracs++;
				if (out_ch.res_num !== want.res_num) begin
					$error("res_num expected %0d got %0d", want.res_num, out_ch.res_num);
					n_errors++;
				end
				if (out_ch.res_den !== want.res_den) begin
					$error("res_den expected %0d got %0d", want.res_den, out_ch.res_den);
					n_errors++;
				end
				if (out_ch.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, out_ch.status);
					n_errors++;
				end
				if (out_ch.order !== want.order) begin
					$error("order expected %0d got %0d", want.order, out_ch.order);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_rational_arithmetic_unit: done, errors");
			$finish;
		end
	end

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.action = '0;
		in_ch.a_num  = '0;
		in_ch.a_den  = '0;
		in_ch.b_num  = '0;
		in_ch.b_den  = '0;
		out_ch.ready = 1'b0;

		// directed: each action, field extremes, zero divisors, overflow
		pending_ops.push_back(op(rau_pkg::ACT_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3));
		pending_ops.push_back(op(rau_pkg::ACT_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2));
		pending_ops.push_back(op(rau_pkg::ACT_MUL, -32'sd3, 31'd4, 32'sd8, 31'd9));
		pending_ops.push_back(op(rau_pkg::ACT_DIV, 32'sd5, 31'd7, -32'sd10, 31'd21));
		pending_ops.push_back(op(rau_pkg::ACT_REM, 32'sd7, 31'd2, 32'sd3, 31'd4));
		pending_ops.push_back(op(rau_pkg::ACT_REM, -32'sd7, 31'd2, 32'sd3, 31'd4));
		pending_ops.push_back(op(rau_pkg::ACT_NEG, 32'sd6, 31'd4, 32'sd0, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_CMP, 32'sd1, 31'd3, 32'sd2, 31'd6));
		pending_ops.push_back(op(rau_pkg::ACT_CMP, -32'sd1, 31'd3, 32'sd0, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_CMP, 32'sd5, 31'd3, 32'sd1, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_DIV, 32'sd1, 31'd1, 32'sd0, 31'd5));
		pending_ops.push_back(op(rau_pkg::ACT_REM, 32'sd1, 31'd1, 32'sd0, 31'd5));
		pending_ops.push_back(op(rau_pkg::ACT_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_NEG, 32'h8000_0000, 31'd2, 32'sd0, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_MUL, 32'h8000_0000, 31'd1,
		                         32'h8000_0000, 31'd1));
		pending_ops.push_back(op(rau_pkg::ACT_ADD, 32'h7fff_ffff, 31'h7fff_ffff,
		                         32'h8000_0000, 31'h7fff_ffff));
		pending_ops.push_back(op(rau_pkg::ACT_SUB, 32'h7fff_ffff, 31'h7fff_fffe,
		                         32'h8000_0000, 31'h7fff_ffff));
		pending_ops.push_back(op(rau_pkg::ACT_MUL, 32'sd0, 31'd5, 32'sd9, 31'd7));
		pending_ops.push_back(op(rau_pkg::ACT_DIV, 32'h7fff_ffff, 31'd1,
		                         32'sd1, 31'h7fff_ffff));
		pending_ops.push_back(op(rau_pkg::ACT_NONE, 32'hffff_ffff, 31'h7fff_ffff,
		                         32'hffff_ffff, 31'h7fff_ffff));
		pending_ops.push_back(op(rau_pkg::ACT_CMP, 32'h8000_0000, 31'h7fff_ffff,
		                         32'h7fff_ffff, 31'd1));

		// random: mostly the seven real actions, a few of the unused one
		repeat (N_RANDOM) begin
			pending_ops.push_back(op(($urandom_range(99) < 2) ? rau_pkg::ACT_NONE :
			                         rau_pkg::action_t'($urandom_range(6)),
			                         pick_num(), pick_den(), pick_num(), pick_den()));
		end
		total_ops = pending_ops.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (taken_ops == total_ops && expected_fracs.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d operand transactions, %0d results checked, in %0d cycles",
		         taken_ops, checked_fracs, cycles);
		$display("predicted %0d out-of-range and %0d zero-divisor results",
		         n_range, n_zero);
		if (n_errors == 0 && expected_fracs.size() == 0) begin
			$display("tb_rational_arithmetic_unit: done, clean");
		end else begin
			$display("tb_rational_arithmetic_unit: done, errors");
		end
		$finish;
	end

endmodule
